// ----- src/tbgd_pkg.sv -----
`default_nettype none

package tbgd_pkg;

    // Default width of the wrapping millisecond timebase
    localparam int TIME_BITS_DEF = 32;

    // Fixed field widths
    localparam int NOW_W  = 32;
    localparam int MS_W   = 16;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;
    localparam int S_DW   = 40;
    localparam int M_DW   = 8;

    // Register reset values
    localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [MS_W-1:0] LONG_RST     = 16'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_DEBOUNCE = 3'd0,
        CFG_LONG_MS  = 3'd1,
        CFG_LONG_EN  = 3'd2,
        CFG_INV1     = 3'd3,
        CFG_INV2     = 3'd4
    } t_cfg_idx;

    // Event codes
    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_ONE  = 3'd1,
        EV_TWO  = 3'd2,
        EV_BOTH = 3'd3,
        EV_LONG = 3'd4
    } t_event;

    // Debounced level of one button before and after the current sample
    typedef struct packed {
        logic prev;
        logic cur;
    } t_lane_st;

endpackage

`default_nettype wire

// ----- src/two_button_gesture_debouncer_unit.sv -----
// Channel  Direction  Ports                               Beat contents (low bit up)
// s        in         i_s_tvalid o_s_tready i_s_tdata     raw_button1, raw_button2, now_ms
// m        out        o_m_tvalid i_m_tready o_m_tdata     event_res
// cfg      in         i_cfg_valid o_cfg_ready i_cfg_addr  i_cfg_data: register value
//
// One sample per clock while the output register can move; its event appears on the
// output register in the cycle after acceptance. The lane and gesture state update in
// the acceptance cycle, so the combinational compare and update path sets the rate.
// Reset (synchronous, active low) restores register defaults, clears all but r_event.
// A stalled output holds the input off only while the output register stays full.
`default_nettype none

module two_button_gesture_debouncer_unit
    import tbgd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [S_DW-1:0]   i_s_tdata,   // raw_button1, raw_button2, now_ms[31:0], pad
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [M_DW-1:0]        o_m_tdata,   // event_res[2:0], pad
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    logic [MS_W-1:0]      r_debounce_ms;
    logic [MS_W-1:0]      r_long_ms;
    logic                 r_long_en;
    logic                 r_inv1;
    logic                 r_inv2;
    logic                 r_out_valid;
    t_event               r_event;
    logic                 accept;
    logic [TIME_BITS-1:0] now_t;
    t_lane_st             st1, st2;
    t_event               ev;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RST;
            r_long_ms     <= LONG_RST;
            r_long_en     <= 1'b0;
            r_inv1        <= 1'b0;
            r_inv2        <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DEBOUNCE: r_debounce_ms <= i_cfg_data;
                CFG_LONG_MS:  r_long_ms     <= i_cfg_data;
                CFG_LONG_EN:  r_long_en     <= i_cfg_data[0];
                CFG_INV1:     r_inv1        <= i_cfg_data[0];
                CFG_INV2:     r_inv2        <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Input handshake: take a beat whenever the output register can move
    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign accept     = i_s_tvalid & o_s_tready;
    assign now_t      = TIME_BITS'(i_s_tdata[NOW_W+1:2]);

    // One debounce lane per button
    tbgd_lane #(.TIME_BITS(TIME_BITS)) u_lane1 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_level       (i_s_tdata[0] ^ r_inv1),
        .i_now         (now_t),
        .i_debounce_ms (r_debounce_ms),
        .o_st          (st1)
    );

    tbgd_lane #(.TIME_BITS(TIME_BITS)) u_lane2 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_level       (i_s_tdata[1] ^ r_inv2),
        .i_now         (now_t),
        .i_debounce_ms (r_debounce_ms),
        .o_st          (st2)
    );

    // Gesture merge
    tbgd_combo #(.TIME_BITS(TIME_BITS)) u_combo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_now     (now_t),
        .i_long_en (r_long_en),
        .i_long_ms (r_long_ms),
        .i_st1     (st1),
        .i_st2     (st2),
        .o_event   (ev)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event <= ev;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_DW-3)'(0), r_event};

endmodule

`default_nettype wire

// ----- src/tbgd_lane.sv -----
`default_nettype none

module tbgd_lane
    import tbgd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic                 i_level,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic [MS_W-1:0]      i_debounce_ms,
    output t_lane_st                  o_st
);

    logic                 r_raw_prev, n_raw_prev;
    logic                 r_stable,   n_stable;
    logic [TIME_BITS-1:0] r_change,   n_change;
    logic [TIME_BITS-1:0] since;

    // Edge qualification against the last accepted change (wrapping)
    always_comb begin
        since      = i_now - r_change;
        n_raw_prev = i_level;
        n_stable   = r_stable;
        n_change   = r_change;
        if (i_level != r_raw_prev && since >= TIME_BITS'(i_debounce_ms)) begin
            n_stable = i_level;
            n_change = i_now;
        end
    end

    assign o_st.prev = r_stable;
    assign o_st.cur  = n_stable;

    // Lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_prev <= 1'b0;
            r_stable   <= 1'b0;
            r_change   <= '0;
        end else if (i_accept) begin
            r_raw_prev <= n_raw_prev;
            r_stable   <= n_stable;
            r_change   <= n_change;
        end
    end

endmodule

`default_nettype wire

// ----- src/tbgd_combo.sv -----
`default_nettype none

module tbgd_combo
    import tbgd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic                 i_long_en,
    input  wire logic [MS_W-1:0]      i_long_ms,
    input  t_lane_st                  i_st1,
    input  t_lane_st                  i_st2,
    output t_event                    o_event
);

    logic                 r_combo_active, n_combo_active;
    logic [TIME_BITS-1:0] r_press_start,  n_press_start;
    logic [TIME_BITS-1:0] held_for;
    logic fell1, fell2, rose1, rose2, held1, held2, idle1, idle2;

    // Merge the two lanes into one gesture event
    always_comb begin
        fell1 =  i_st1.prev & ~i_st1.cur;
        fell2 =  i_st2.prev & ~i_st2.cur;
        rose1 = ~i_st1.prev &  i_st1.cur;
        rose2 = ~i_st2.prev &  i_st2.cur;
        held1 =  i_st1.prev &  i_st1.cur;
        held2 =  i_st2.prev &  i_st2.cur;
        idle1 = ~i_st1.prev & ~i_st1.cur;
        idle2 = ~i_st2.prev & ~i_st2.cur;
        held_for       = i_now - r_press_start;
        n_combo_active = r_combo_active;
        n_press_start  = r_press_start;
        o_event        = EV_NONE;
        if (fell1 && !r_combo_active) begin
            if (held2) n_combo_active = 1'b1;
            else       o_event = EV_ONE;
        end else if (fell2 && !r_combo_active) begin
            if (held1) n_combo_active = 1'b1;
            else       o_event = EV_TWO;
        end else if (i_long_en && (rose1 || rose2)) begin
            n_press_start = i_now;
        end else if (r_combo_active && idle1 && idle2) begin
            n_combo_active = 1'b0;
            // zero start time means no press was recorded
            if (i_long_en && r_press_start != '0 &&
                held_for >= TIME_BITS'(i_long_ms)) begin
                n_press_start = '0;
                o_event       = EV_LONG;
            end else begin
                o_event = EV_BOTH;
            end
        end
    end

    // Gesture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combo_active <= 1'b0;
            r_press_start  <= '0;
        end else if (i_accept) begin
            r_combo_active <= n_combo_active;
            r_press_start  <= n_press_start;
        end
    end

`ifndef SYNTHESIS
    // long event needs the feature switched on
    a_long_needs_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_long_en |-> o_event != EV_LONG)
        else $error("long event while long press disabled");

    // combined events only close an active combo
    a_both_needs_combo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (o_event == EV_BOTH || o_event == EV_LONG) |-> r_combo_active)
        else $error("combined event without active combo");

    // long event consumes the recorded start time
    a_long_clears_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_event == EV_LONG |=> r_press_start == '0 && !r_combo_active)
        else $error("long event left press state behind");
`endif

endmodule

`default_nettype wire

// ----- tb/two_button_gesture_debouncer_unit_tb.sv -----
`default_nettype none

module two_button_gesture_debouncer_unit_tb;
    import tbgd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1950;

    // Predicts the event of every accepted sample and checks the output beats in order
    class gesture_scoreboard;
        logic [MS_W-1:0]  debounce_ms;
        logic [MS_W-1:0]  long_ms;
        logic             long_en;
        logic             invert [2];
        logic             raw_prev [2];
        logic             stable [2];
        logic             was_stable [2];
        logic [NOW_W-1:0] changed_at [2];
        logic             combo;
        logic [NOW_W-1:0] press_start;
        t_event           pending_events[$];
        int               mismatch_count;
        int               beats_checked;
        int               event_hist [5];

        function new();
            debounce_ms    = DEBOUNCE_RST;
            long_ms        = LONG_RST;
            long_en        = 1'b0;
            combo          = 1'b0;
            press_start    = '0;
            mismatch_count = 0;
            beats_checked  = 0;
            foreach (raw_prev[b]) begin
                invert[b]     = 1'b0;
                raw_prev[b]   = 1'b0;
                stable[b]     = 1'b0;
                was_stable[b] = 1'b0;
                changed_at[b] = '0;
            end
            foreach (event_hist[e]) event_hist[e] = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
            case (t_cfg_idx'(addr))
                CFG_DEBOUNCE: debounce_ms = val;
                CFG_LONG_MS:  long_ms     = val;
                CFG_LONG_EN:  long_en     = val[0];
                CFG_INV1:     invert[0]   = val[0];
                CFG_INV2:     invert[1]   = val[0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic pin1, logic pin2, logic [NOW_W-1:0] now);
            logic             lvl [2];
            logic             fell [2];
            logic             rose [2];
            logic             kept [2];
            logic             quiet [2];
            logic [NOW_W-1:0] span;
            t_event           ev;
            lvl[0] = pin1 ^ invert[0];
            lvl[1] = pin2 ^ invert[1];
            ev     = EV_NONE;
            // per button: an edge only lands once the hold-off since its last change is over
            for (int b = 0; b < 2; b++) begin
                span = now - changed_at[b];
                if (lvl[b] != raw_prev[b] && span >= NOW_W'(debounce_ms)) begin
                    stable[b]     = lvl[b];
                    changed_at[b] = now;
                end
                raw_prev[b] = lvl[b];
                fell[b]  = was_stable[b] && !stable[b];
                rose[b]  = !was_stable[b] && stable[b];
                kept[b]  = was_stable[b] && stable[b];
                quiet[b] = !was_stable[b] && !stable[b];
            end
            // gesture decode, first match wins
            if (fell[0] && !combo) begin
                if (kept[1]) combo = 1'b1;
                else ev = EV_ONE;
            end else if (fell[1] && !combo) begin
                if (kept[0]) combo = 1'b1;
                else ev = EV_TWO;
            end else if (long_en && (rose[0] || rose[1])) begin
                press_start = now;
            end else if (combo && quiet[0] && quiet[1]) begin
                combo = 1'b0;
                span  = now - press_start;
                // a press stamped at zero reads as no press at all
                if (long_en && press_start != '0 && span >= NOW_W'(long_ms)) begin
                    press_start = '0;
                    ev          = EV_LONG;
                end else begin
                    ev = EV_BOTH;
                end
            end
            was_stable[0] = stable[0];
            was_stable[1] = stable[1];
            pending_events.push_back(ev);
        endfunction

        function void check_event(logic [2:0] got);
            t_event want;
            if (pending_events.size() == 0) begin
                $error("event beat %0d arrived with no sample waiting for it", got);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                beats_checked++;
                if (got <= 3'd4) event_hist[got]++;
                if (got !== want) begin
                    $error("event_res: expected %0d, got %0d", want, got);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [S_DW-1:0]   i_s_tdata;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [M_DW-1:0]   o_m_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_data;

    gesture_scoreboard sb = new();

    // stimulus-side view of the buttons and the register settings
    logic [NOW_W-1:0] t_ms;
    logic             press1;
    logic             press2;
    int unsigned      deb_cur;
    int unsigned      long_cur;
    logic             inv1_cur;
    logic             inv2_cur;
    logic             no_idle;
    int               n_sent;
    int               n_settings;
    int               cycle_count;

    two_button_gesture_debouncer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // every beat is seen at the rising edge: samples and register writes feed
    // the predictor, output beats are checked against it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_sample(i_s_tdata[0], i_s_tdata[1], i_s_tdata[NOW_W+1:2]);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_reg(i_cfg_addr, i_cfg_data);
            if (o_m_tvalid && i_m_tready)
                sb.check_event(o_m_tdata[2:0]);
        end
    end

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // output side: random stall before each beat
    initial begin : sink_side
        int unsigned stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_sample(input logic pin1, input logic pin2, input logic [NOW_W-1:0] ts);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= {{(S_DW-NOW_W-2){1'b0}}, ts, pin2, pin1};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        n_sent++;
    endtask

    // advance the timestamp by dt and send the current pressed levels as pin levels
    task automatic tick(input logic pr1, input logic pr2, input int unsigned dt);
        t_ms = t_ms + dt;
        send_sample(pr1 ^ inv1_cur, pr2 ^ inv2_cur, t_ms);
    endtask

    task automatic at(input logic pr1, input logic pr2, input logic [NOW_W-1:0] ts);
        t_ms = ts;
        tick(pr1, pr2, 0);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending_events.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int unsigned deb, input int unsigned lng,
                             input logic en, input logic v1, input logic v2);
        write_reg(CFG_DEBOUNCE, CFG_DW'(deb));
        write_reg(CFG_LONG_MS, CFG_DW'(lng));
        write_reg(CFG_LONG_EN, CFG_DW'(en));
        write_reg(CFG_INV1, CFG_DW'(v1));
        write_reg(CFG_INV2, CFG_DW'(v2));
        deb_cur  = deb;
        long_cur = lng;
        inv1_cur = v1;
        inv2_cur = v2;
        n_settings++;
    endtask

    function automatic int unsigned short_dt();
        return (deb_cur == 0) ? 0 : $urandom_range(0, deb_cur - 1);
    endfunction

    // clean edge after the hold-off, then a few bounces inside it
    task automatic move_button(input int btn, input logic level);
        int unsigned n;
        if (btn == 1) press1 = level;
        else press2 = level;
        tick(press1, press2, deb_cur + $urandom_range(1, 20));
        n = $urandom_range(0, 2);
        repeat (n) begin
            if (btn == 1) press1 = !level;
            else press2 = !level;
            tick(press1, press2, short_dt());
            if (btn == 1) press1 = level;
            else press2 = level;
            tick(press1, press2, short_dt());
        end
    endtask

    task automatic hold_for();
        repeat ($urandom_range(0, 3)) tick(press1, press2, $urandom_range(0, long_cur / 2 + 20));
    endtask

    // one press gesture: single button, staggered pair or simultaneous pair
    task automatic play_gesture();
        int unsigned kind;
        int          first;
        kind  = $urandom_range(0, 3);
        first = $urandom_range(1, 2);
        if (kind < 2) begin
            move_button(kind + 1, 1'b1);
            hold_for();
            move_button(kind + 1, 1'b0);
        end else if (kind == 2) begin
            move_button(first, 1'b1);
            if ($urandom_range(0, 1)) hold_for();
            move_button(3 - first, 1'b1);
            hold_for();
            first = $urandom_range(1, 2);
            move_button(first, 1'b0);
            move_button(3 - first, 1'b0);
        end else begin
            press1 = 1'b1;
            press2 = 1'b1;
            tick(press1, press2, deb_cur + $urandom_range(1, 20));
            hold_for();
            if ($urandom_range(0, 1)) begin
                press1 = 1'b0;
                press2 = 1'b0;
                tick(press1, press2, deb_cur + $urandom_range(1, 20));
            end else begin
                move_button(first, 1'b0);
                move_button(3 - first, 1'b0);
            end
        end
        // settled idle sample lets the pair decode
        tick(press1, press2, deb_cur + $urandom_range(1, 20));
    endtask

    // random pins, either a short step or a jump anywhere in the timebase
    task automatic noise_burst();
        repeat ($urandom_range(1, 4)) begin
            press1 = 1'($urandom_range(0, 1));
            press2 = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) at(press1, press2, $urandom());
            else tick(press1, press2, $urandom_range(0, 2 * deb_cur + 2));
        end
    endtask

    initial begin : main
        int          phase;
        int          phase_end;
        int unsigned deb;
        int unsigned lng;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_data  = '0;
        t_ms        = '0;
        press1      = 1'b0;
        press2      = 1'b0;
        deb_cur     = 32'(DEBOUNCE_RST);
        long_cur    = 32'(LONG_RST);
        inv1_cur    = 1'b0;
        inv2_cur    = 1'b0;
        no_idle     = 1'b0;
        n_sent      = 0;
        n_settings  = 1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: early edge refused, rejected edge remembered, each single release
        at(1'b1, 1'b0, 32'd10);
        at(1'b1, 1'b0, 32'd20);
        at(1'b0, 1'b0, 32'd30);
        at(1'b1, 1'b0, 32'd100);
        at(1'b0, 1'b0, 32'd200);
        at(1'b0, 1'b1, 32'd300);
        at(1'b0, 1'b0, 32'd400);
        // pair, long press off
        at(1'b1, 1'b1, 32'd500);
        at(1'b0, 1'b1, 32'd700);
        at(1'b0, 1'b0, 32'd800);
        at(1'b0, 1'b0, 32'd900);

        // long press on: press stamped at zero never counts as long
        wait_drained();
        configure(0, 32, 1'b1, 1'b0, 1'b0);
        at(1'b1, 1'b1, 32'd0);
        at(1'b0, 1'b1, 32'd10);
        at(1'b0, 1'b0, 32'd20);
        at(1'b0, 1'b0, 32'd30);
        // long press across the timebase wrap
        at(1'b1, 1'b1, 32'hFFFF_FFF0);
        at(1'b0, 1'b1, 32'hFFFF_FFF8);
        at(1'b0, 1'b0, 32'hFFFF_FFFC);
        at(1'b0, 1'b0, 32'd16);
        // short pair release keeps its start stamp
        at(1'b1, 1'b1, 32'd100);
        at(1'b0, 1'b1, 32'd110);
        at(1'b0, 1'b0, 32'd120);
        at(1'b0, 1'b0, 32'd125);

        // random phases, each under its own register setting
        phase = 0;
        while (n_sent < 23 + RANDOM_ITEMS) begin
            wait_drained();
            case (phase)
                0: begin
                    deb = 0;
                    lng = 0;
                end
                1: begin
                    deb = 16'hFFFF;
                    lng = 16'hFFFF;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: deb = 0;
                        1: deb = 1;
                        2: deb = 16'hFFFF;
                        default: deb = $urandom_range(2, 60);
                    endcase
                    case ($urandom_range(0, 4))
                        0: lng = 0;
                        1: lng = 16'hFFFF;
                        default: lng = $urandom_range(10, 300);
                    endcase
                end
            endcase
            configure(deb, lng, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            phase_end = n_sent + $urandom_range(100, 200);
            while (n_sent < phase_end) begin
                if ($urandom_range(0, 7) == 0) noise_burst();
                else play_gesture();
            end
            phase++;
        end

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (sb.pending_events.size() != 0) begin
            $error("%0d expected event beats never arrived", sb.pending_events.size());
            sb.mismatch_count++;
        end
        $display("Run covered %0d samples under %0d register settings, %0d event beats checked.",
                 n_sent, n_settings, sb.beats_checked);
        $display("Events seen: none %0d, button one %0d, button two %0d, both %0d, both long %0d",
                 sb.event_hist[0], sb.event_hist[1], sb.event_hist[2], sb.event_hist[3],
                 sb.event_hist[4]);
        if (sb.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
src/tbgd_pkg.sv
src/tbgd_lane.sv
src/tbgd_combo.sv
src/two_button_gesture_debouncer_unit.sv
tb/two_button_gesture_debouncer_unit_tb.sv
